// ===== rtl/tsdb_pkg.sv =====
// Shared types, codes and decode helpers for the temperature segment display blinker.
// No dependencies; the top level, tsdb_image and the bench import this package.
package tsdb_pkg;

    localparam int TEMP_W  = 16;
    localparam int SEG_W   = 7;
    localparam int COUNT_W = 3;

    localparam logic [COUNT_W-1:0] TENTHS_PER_PHASE = 3'd5;
    localparam logic [COUNT_W-1:0] BLINK_PHASES     = 3'd6;
    localparam logic [COUNT_W-1:0] BLINK_COUNT_MAX  = 3'd7;

    localparam logic [SEG_W-1:0] SEG_LO_LEFT = 7'h38;
    localparam logic [SEG_W-1:0] SEG_LO_MID  = 7'h5c;
    localparam logic [SEG_W-1:0] SEG_HI_LEFT = 7'h76;
    localparam logic [SEG_W-1:0] SEG_HI_MID  = 7'h06;

    localparam logic [9:0] MAG_MAX = 10'd999;

    typedef enum logic [1:0] {
        OP_REFRESH = 2'd0,
        OP_BLINK   = 2'd1,
        OP_SET     = 2'd2
    } opcode_t;

    typedef enum logic [1:0] {
        MODE_NORMAL = 2'd0,
        MODE_OFF    = 2'd1,
        MODE_ON     = 2'd2
    } mode_t;

    typedef enum logic [1:0] {
        FILL_NORMAL = 2'd0,
        FILL_OFF    = 2'd1,
        FILL_ON     = 2'd2
    } fill_t;

    typedef enum logic [1:0] {
        REG_DISPLAY_MODE = 2'd0,
        REG_BLANK_CODE   = 2'd1,
        REG_LOW_CODE     = 2'd2,
        REG_HIGH_CODE    = 2'd3
    } reg_index_t;

    typedef struct packed {
        logic             celsius;
        logic             point;
        logic [SEG_W-1:0] right;
        logic [SEG_W-1:0] middle;
        logic [SEG_W-1:0] left;
    } image_t;

    typedef struct packed {
        logic [TEMP_W-1:0] blank_code;
        logic [TEMP_W-1:0] low_code;
        logic [TEMP_W-1:0] high_code;
    } codes_t;

    function automatic logic [SEG_W-1:0] digit_segments(input logic [3:0] digit);
        logic [SEG_W-1:0] seg;
        case (digit)
            4'd0:    seg = 7'h3f;
            4'd1:    seg = 7'h06;
            4'd2:    seg = 7'h5b;
            4'd3:    seg = 7'h4f;
            4'd4:    seg = 7'h66;
            4'd5:    seg = 7'h6d;
            4'd6:    seg = 7'h7d;
            4'd7:    seg = 7'h27;
            4'd8:    seg = 7'h7f;
            4'd9:    seg = 7'h6f;
            default: seg = '0;
        endcase
        return seg;
    endfunction

endpackage

// ===== rtl/tsdb_cmd_if.sv =====
// Command channel: opcode, temperature and tenth tick with valid/ready.
// Depends on nothing.
interface tsdb_cmd_if;
    logic               valid;
    logic               ready;
    logic [1:0]         opcode;
    logic signed [15:0] temperature;
    logic               tenth_tick;

    modport source (output valid, opcode, temperature, tenth_tick, input ready);
    modport sink   (input valid, opcode, temperature, tenth_tick, output ready);
endinterface

// ===== rtl/tsdb_disp_if.sv =====
// Display result channel: three digit images, marks and fill code with valid/ready.
// Depends on nothing.
interface tsdb_disp_if;
    logic       valid;
    logic       ready;
    logic [6:0] left_digit_segments;
    logic [6:0] middle_digit_segments;
    logic [6:0] right_digit_segments;
    logic       point_mark;
    logic       celsius_mark;
    logic [1:0] whole_fill;

    modport source (output valid, left_digit_segments, middle_digit_segments,
                    right_digit_segments, point_mark, celsius_mark, whole_fill,
                    input ready);
    modport sink   (input valid, left_digit_segments, middle_digit_segments,
                    right_digit_segments, point_mark, celsius_mark, whole_fill,
                    output ready);
endinterface

// ===== rtl/temperature_segment_display_blinker.sv =====
// Top level of the three-digit temperature display with blink; holds the command
// register, display state, configuration and result register. Uses tsdb_pkg,
// tsdb_cmd_if, tsdb_disp_if and tsdb_image.
//
// A command is taken while the command register is empty or moves on; a refresh waits
// there while the result register is full and unread. Each accepted command is held
// in a command register; a refresh then passes through a single decode path into the
// result register, which offers its image, and the block sustains one command per
// cycle while the result register is free. The result register frees as its transfer
// completes, so a new command is taken while a result still waits. Set and blink
// commands give no result; neither does the unused opcode. Configuration writes take
// effect at once and are meant for idle periods. The display mode resets to all off.
module temperature_segment_display_blinker
    import tsdb_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_write_en,
    input  logic [1:0]        cfg_index,
    input  logic [TEMP_W-1:0] cfg_data,
    tsdb_cmd_if.sink          cmd,
    tsdb_disp_if.source       disp
);

    logic [1:0]         mode_reg;
    codes_t             codes_reg;

    logic               stage_valid_reg;
    logic [1:0]         stage_opcode_reg;
    logic [TEMP_W-1:0]  stage_temp_reg;
    logic               stage_tick_reg;

    logic [TEMP_W-1:0]  shown_reg, shown_next;
    logic               blink_active_reg, blink_active_next;
    logic [TEMP_W-1:0]  blink_value_reg, blink_value_next;
    logic [COUNT_W-1:0] blink_count_reg, blink_count_next;
    logic [COUNT_W-1:0] tenth_count_reg, tenth_count_next;
    image_t             seg_image_reg, seg_image_next;
    fill_t              fill_next;

    logic               out_valid_reg, out_valid_next;
    image_t             out_image_reg;
    fill_t              out_fill_reg;

    logic               out_free;
    logic               stage_is_refresh;
    logic               stage_advance;
    logic [TEMP_W-1:0]  decode_value;
    image_t             decode_image;
    logic [COUNT_W-1:0] tenth_inc;

    assign out_free         = !out_valid_reg || disp.ready;
    assign stage_is_refresh = (stage_opcode_reg == OP_REFRESH);
    assign stage_advance    = stage_valid_reg && (!stage_is_refresh || out_free);
    assign cmd.ready        = !stage_valid_reg || stage_advance;
    assign decode_value     = blink_active_reg ? blink_value_reg : shown_reg;

    tsdb_image u_image
    (
        .value (decode_value),
        .codes (codes_reg),
        .image (decode_image)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg             <= MODE_OFF;
            codes_reg.blank_code <= 16'd1000;
            codes_reg.low_code   <= 16'd1001;
            codes_reg.high_code  <= 16'd1002;
        end
        else if (cfg_write_en)
        begin
            unique case (reg_index_t'(cfg_index))
                REG_DISPLAY_MODE: mode_reg             <= cfg_data[1:0];
                REG_BLANK_CODE:   codes_reg.blank_code <= cfg_data;
                REG_LOW_CODE:     codes_reg.low_code   <= cfg_data;
                REG_HIGH_CODE:    codes_reg.high_code  <= cfg_data;
                default:          ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
        end
        else if (cmd.ready)
        begin
            stage_valid_reg <= cmd.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.valid && cmd.ready)
        begin
            stage_opcode_reg <= cmd.opcode;
            stage_temp_reg   <= cmd.temperature;
            stage_tick_reg   <= cmd.tenth_tick;
        end
    end

    always_comb
    begin
        shown_next        = shown_reg;
        blink_active_next = blink_active_reg;
        blink_value_next  = blink_value_reg;
        blink_count_next  = blink_count_reg;
        tenth_count_next  = tenth_count_reg;
        seg_image_next    = seg_image_reg;
        fill_next         = FILL_NORMAL;
        tenth_inc         = tenth_count_reg + 3'd1;

        if (stage_advance)
        begin
            case (stage_opcode_reg)
                OP_BLINK:
                begin
                    blink_active_next = 1'b1;
                    blink_value_next  = stage_temp_reg;
                    blink_count_next  = '0;
                end
                OP_SET:
                begin
                    shown_next = stage_temp_reg;
                end
                OP_REFRESH:
                begin
                    case (mode_reg)
                        MODE_OFF:
                        begin
                            seg_image_next = '0;
                            fill_next      = FILL_OFF;
                        end
                        MODE_ON:
                        begin
                            seg_image_next = '1;
                            fill_next      = FILL_ON;
                        end
                        default:
                        begin
                            if (blink_active_reg)
                            begin
                                if (stage_tick_reg)
                                begin
                                    tenth_count_next = tenth_inc;
                                    if (tenth_inc >= TENTHS_PER_PHASE)
                                    begin
                                        tenth_count_next = '0;
                                        if (blink_count_reg < BLINK_COUNT_MAX)
                                        begin
                                            blink_count_next = blink_count_reg + 3'd1;
                                        end
                                    end
                                end
                                // hold the last image once the blink runs out
                                if (blink_count_next >= BLINK_PHASES)
                                begin
                                    blink_active_next = 1'b0;
                                end
                                else if (blink_count_next[0])
                                begin
                                    seg_image_next = decode_image;
                                end
                                else
                                begin
                                    seg_image_next = '0;
                                end
                            end
                            else
                            begin
                                seg_image_next = decode_image;
                            end
                        end
                    endcase
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shown_reg        <= '0;
            blink_active_reg <= 1'b0;
            blink_value_reg  <= '0;
            blink_count_reg  <= '0;
            tenth_count_reg  <= '0;
            seg_image_reg    <= '0;
        end
        else
        begin
            shown_reg        <= shown_next;
            blink_active_reg <= blink_active_next;
            blink_value_reg  <= blink_value_next;
            blink_count_reg  <= blink_count_next;
            tenth_count_reg  <= tenth_count_next;
            seg_image_reg    <= seg_image_next;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg && !disp.ready;
        if (stage_advance && stage_is_refresh)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (stage_advance && stage_is_refresh)
        begin
            out_image_reg <= seg_image_next;
            out_fill_reg  <= fill_next;
        end
    end

    assign disp.valid                 = out_valid_reg;
    assign disp.left_digit_segments   = out_image_reg.left;
    assign disp.middle_digit_segments = out_image_reg.middle;
    assign disp.right_digit_segments  = out_image_reg.right;
    assign disp.point_mark            = out_image_reg.point;
    assign disp.celsius_mark          = out_image_reg.celsius;
    assign disp.whole_fill            = out_fill_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        tenth_count_reg < TENTHS_PER_PHASE)
        else $error("tenth counter passed its phase length");

    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.valid && cmd.ready |=> stage_valid_reg)
        else $error("accepted command lost before the command register");

    assert property (@(posedge clk) disable iff (!rst_n)
        disp.valid && (disp.whole_fill == FILL_OFF) |-> (out_image_reg == '0))
        else $error("whole-off result carries lit segments");

    assert property (@(posedge clk) disable iff (!rst_n)
        disp.valid && (disp.whole_fill == FILL_ON) |-> (out_image_reg == '1))
        else $error("whole-on result carries dark segments");

    assert property (@(posedge clk) disable iff (!rst_n)
        disp.valid && !disp.ready |=> disp.valid && $stable(out_image_reg))
        else $error("stalled result dropped or changed");

endmodule

// ===== rtl/tsdb_image.sv =====
// Value-to-segment decode: special codes, magnitude, saturation and digit split.
// Depends on tsdb_pkg.
module tsdb_image
    import tsdb_pkg::*;
(
    input  logic [TEMP_W-1:0] value,
    input  codes_t            codes,
    output image_t            image
);

    logic [16:0] mag_full;
    logic [9:0]  mag;
    logic [15:0] hund_prod;
    logic [3:0]  hund;
    logic [9:0]  hund_scaled;
    logic [6:0]  rem100;
    logic [14:0] tens_prod;
    logic [3:0]  tens;
    logic [6:0]  tens_scaled;
    logic [3:0]  units;

    always_comb
    begin
        mag_full = value[TEMP_W-1] ? (17'h10000 - {1'b0, value}) : {1'b0, value};
        mag      = (mag_full > 17'(MAG_MAX)) ? MAG_MAX : mag_full[9:0];

        // divide by 100 and by 10 through reciprocals, exact over 0..999
        hund_prod   = 16'(mag) * 16'd41;
        hund        = hund_prod[15:12];
        hund_scaled = 10'(hund) * 10'd100;
        rem100      = 7'(mag - hund_scaled);
        tens_prod   = 15'(rem100) * 15'd205;
        tens        = tens_prod[14:11];
        tens_scaled = 7'(tens) * 7'd10;
        units       = 4'(rem100 - tens_scaled);

        image = '0;
        if (value == codes.blank_code)
        begin
            image = '0;
        end
        else if (value == codes.low_code)
        begin
            image.left   = SEG_LO_LEFT;
            image.middle = SEG_LO_MID;
        end
        else if (value == codes.high_code)
        begin
            image.left   = SEG_HI_LEFT;
            image.middle = SEG_HI_MID;
        end
        else
        begin
            image.left    = (hund != 4'd0) ? digit_segments(hund) : '0;
            image.middle  = digit_segments(tens);
            image.right   = digit_segments(units);
            image.point   = 1'b1;
            image.celsius = 1'b1;
        end
    end

endmodule

// ===== test/tb.sv =====
// Self-checking bench for temperature_segment_display_blinker: random and directed
// commands, display frames checked against a local predictor. Uses tsdb_pkg,
// tsdb_cmd_if, tsdb_disp_if and the block itself.
module tb;
    import tsdb_pkg::*;

    localparam logic [1:0] OP_SPARE    = 2'd3;
    localparam logic [1:0] MODE_SPARE  = 2'd3;
    localparam int         CYCLE_LIMIT = 120000;
    localparam int         SETTLE_CYCLES = 6;
    localparam int         DRAIN_LIMIT = 400;
    localparam int         PHASE_ITEMS = 90;
    localparam logic [69:0] GLYPHS = {7'h6f, 7'h7f, 7'h27, 7'h7d, 7'h6d,
                                      7'h66, 7'h4f, 7'h5b, 7'h06, 7'h3f};

    typedef struct {
        logic [1:0]  op;
        logic [15:0] temp;
        logic        tick;
        bit          pause;
    } cmd_item_t;

    typedef struct {
        image_t img;
        fill_t  fill;
    } frame_t;

    logic              clk;
    logic              rst_n;
    logic              cfg_write_en;
    logic [1:0]        cfg_index;
    logic [TEMP_W-1:0] cfg_data;

    tsdb_cmd_if  cmd_ch ();
    tsdb_disp_if disp_ch ();

    temperature_segment_display_blinker uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .cmd          (cmd_ch),
        .disp         (disp_ch)
    );

    cmd_item_t cmds_pending[$];
    frame_t    frames_due[$];

    int  errors = 0;
    int  queued = 0;
    int  taken = 0;
    int  cycles = 0;
    int  send_gap = 0;
    int  ready_wait = 0;
    bit  steady = 0;

    logic [1:0]  mode_sel = MODE_OFF;
    logic [15:0] code_blank = 16'd1000;
    logic [15:0] code_low = 16'd1001;
    logic [15:0] code_high = 16'd1002;
    logic [15:0] shown_temp = '0;
    logic        blink_on = 1'b0;
    logic [15:0] blink_val = '0;
    logic [2:0]  blink_cnt = '0;
    logic [2:0]  tenth_cnt = '0;
    image_t      image_held = '0;

    function automatic int pick_gap();
        return steady ? 0 : $urandom_range(0, 4);
    endfunction

    function automatic image_t render(logic [15:0] v);
        image_t      img;
        logic [16:0] mag;
        int          m;
        img = '0;
        if (v == code_blank)
            return img;
        if (v == code_low)
        begin
            img.left = SEG_LO_LEFT;
            img.middle = SEG_LO_MID;
            return img;
        end
        if (v == code_high)
        begin
            img.left = SEG_HI_LEFT;
            img.middle = SEG_HI_MID;
            return img;
        end
        mag = v[15] ? 17'h10000 - {1'b0, v} : {1'b0, v};
        m = (mag > 17'd999) ? 999 : int'(mag);
        img.left = (m / 100 != 0) ? GLYPHS[(m / 100) * 7 +: 7] : '0;
        img.middle = GLYPHS[((m % 100) / 10) * 7 +: 7];
        img.right = GLYPHS[(m % 10) * 7 +: 7];
        img.point = 1'b1;
        img.celsius = 1'b1;
        return img;
    endfunction

    task automatic advance_display(logic [1:0] op, logic [15:0] temp, logic tick);
        frame_t f;
        case (op)
            OP_BLINK:
            begin
                blink_on = 1'b1;
                blink_val = temp;
                blink_cnt = '0;
            end
            OP_SET:
                shown_temp = temp;
            OP_REFRESH:
            begin
                f.fill = FILL_NORMAL;
                if (mode_sel == MODE_OFF)
                begin
                    image_held = '0;
                    f.fill = FILL_OFF;
                end
                else if (mode_sel == MODE_ON)
                begin
                    image_held = '1;
                    f.fill = FILL_ON;
                end
                else if (blink_on)
                begin
                    if (tick)
                    begin
                        tenth_cnt = tenth_cnt + 3'd1;
                        if (tenth_cnt >= TENTHS_PER_PHASE)
                        begin
                            tenth_cnt = '0;
                            if (blink_cnt != BLINK_COUNT_MAX)
                                blink_cnt = blink_cnt + 3'd1;
                        end
                    end
                    // hold the last image once the blink has run its course
                    if (blink_cnt >= BLINK_PHASES)
                        blink_on = 1'b0;
                    else if (blink_cnt[0])
                        image_held = render(blink_val);
                    else
                        image_held = '0;
                end
                else
                    image_held = render(shown_temp);
                f.img = image_held;
                frames_due.push_back(f);
            end
            default: ;
        endcase
    endtask

    task automatic report(string what, int got, int want);
        $display("mismatch on %s at cycle %0d: got %0h, expected %0h", what, cycles, got, want);
        errors++;
    endtask

    task automatic write_reg(reg_index_t idx, logic [15:0] val);
        @(posedge clk);
        cfg_write_en <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        case (idx)
            REG_DISPLAY_MODE: mode_sel = val[1:0];
            REG_BLANK_CODE:   code_blank = val;
            REG_LOW_CODE:     code_low = val;
            REG_HIGH_CODE:    code_high = val;
            default: ;
        endcase
        @(posedge clk);
        cfg_write_en <= 1'b0;
    endtask

    task automatic queue_cmd(logic [1:0] op, logic [15:0] temp, logic tick);
        cmd_item_t it;
        it.op = op;
        it.temp = temp;
        it.tick = tick;
        it.pause = 1'b0;
        cmds_pending.push_back(it);
        queued++;
    endtask

    function automatic logic [15:0] pick_extreme();
        case ($urandom_range(0, 7))
            0:       return 16'h8000;
            1:       return 16'h7fff;
            2:       return 16'hffff;
            3:       return 16'h0000;
            4:       return 16'd999;
            5:       return 16'd1000;
            6:       return -16'sd999;
            default: return -16'sd1000;
        endcase
    endfunction

    function automatic logic [15:0] pick_code();
        case ($urandom_range(0, 3))
            0, 1:    return 16'($urandom_range(0, 2200) - 1100);
            2:       return 16'($urandom);
            default: return pick_extreme();
        endcase
    endfunction

    function automatic logic [15:0] pick_temp();
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: return 16'($urandom_range(0, 2200) - 1100);
            5:
            begin
                case ($urandom_range(0, 2))
                    0:       return code_blank;
                    1:       return code_low;
                    default: return code_high;
                endcase
            end
            6:       return pick_extreme();
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic queue_episode();
        int        len;
        int        r;
        cmd_item_t hold;
        if ($urandom_range(0, 9) < 6)
        begin
            queue_cmd(OP_BLINK, pick_temp(), 1'($urandom));
            len = $urandom_range(10, 45);
            repeat (len)
            begin
                r = $urandom_range(0, 99);
                if (r < 85)
                    queue_cmd(OP_REFRESH, pick_temp(), $urandom_range(0, 99) < 80);
                else if (r < 95)
                    queue_cmd(OP_SET, pick_temp(), 1'($urandom));
                else if (r < 98)
                    queue_cmd(OP_SPARE, pick_temp(), 1'($urandom));
                else
                    queue_cmd(OP_BLINK, pick_temp(), 1'($urandom));
            end
        end
        else
        begin
            len = $urandom_range(5, 15);
            repeat (len)
                queue_cmd(2'($urandom_range(0, 3)), pick_temp(), 1'($urandom));
        end
        if ($urandom_range(0, 7) == 0)
        begin
            hold = '{op: OP_REFRESH, temp: '0, tick: 1'b0, pause: 1'b1};
            cmds_pending.push_back(hold);
        end
    endtask

    task automatic settle();
        int waited;
        waited = 0;
        while (cmds_pending.size() != 0 || taken != queued)
            @(posedge clk);
        while (frames_due.size() != 0 && waited < DRAIN_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        if (frames_due.size() != 0)
        begin
            report("frames never delivered", 0, frames_due.size());
            frames_due.delete();
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("FAILED: results differ");
            $finish;
        end
    end

    always @(posedge clk or negedge rst_n)
    begin : drive_cmd
        cmd_item_t nxt;
        if (!rst_n)
        begin
            cmd_ch.valid <= 1'b0;
            send_gap <= 0;
        end
        else if (!cmd_ch.valid || cmd_ch.ready)
        begin
            if (send_gap != 0)
            begin
                send_gap <= send_gap - 1;
                cmd_ch.valid <= 1'b0;
            end
            else if (cmds_pending.size() == 0)
                cmd_ch.valid <= 1'b0;
            else if (cmds_pending[0].pause)
            begin
                cmd_ch.valid <= 1'b0;
                if (!cmd_ch.valid && frames_due.size() == 0)
                    void'(cmds_pending.pop_front());
            end
            else
            begin
                nxt = cmds_pending.pop_front();
                cmd_ch.valid <= 1'b1;
                cmd_ch.opcode <= nxt.op;
                cmd_ch.temperature <= nxt.temp;
                cmd_ch.tenth_tick <= nxt.tick;
                send_gap <= pick_gap();
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin : watch_display
        frame_t want;
        int     w;
        if (!rst_n)
        begin
            disp_ch.ready <= 1'b0;
            ready_wait <= 0;
        end
        else
        begin
            if (cmd_ch.valid && cmd_ch.ready)
            begin
                advance_display(cmd_ch.opcode, cmd_ch.temperature, cmd_ch.tenth_tick);
                taken++;
            end
            if (disp_ch.valid && disp_ch.ready)
            begin
                if (frames_due.size() == 0)
                    report("frame with none pending", disp_ch.whole_fill, 0);
                else
                begin
                    want = frames_due.pop_front();
                    if (disp_ch.left_digit_segments !== want.img.left)
                        report("left digit", disp_ch.left_digit_segments, want.img.left);
                    if (disp_ch.middle_digit_segments !== want.img.middle)
                        report("middle digit", disp_ch.middle_digit_segments, want.img.middle);
                    if (disp_ch.right_digit_segments !== want.img.right)
                        report("right digit", disp_ch.right_digit_segments, want.img.right);
                    if (disp_ch.point_mark !== want.img.point)
                        report("point mark", disp_ch.point_mark, want.img.point);
                    if (disp_ch.celsius_mark !== want.img.celsius)
                        report("celsius mark", disp_ch.celsius_mark, want.img.celsius);
                    if (disp_ch.whole_fill !== want.fill)
                        report("whole fill", disp_ch.whole_fill, want.fill);
                end
                w = pick_gap();
                ready_wait <= w;
                disp_ch.ready <= (w == 0);
            end
            else if (ready_wait != 0)
            begin
                ready_wait <= ready_wait - 1;
                disp_ch.ready <= (ready_wait == 1);
            end
            else
                disp_ch.ready <= 1'b1;
        end
    end

    initial
    begin : stimulus
        int         start;
        logic [1:0] mode_pick;
        rst_n = 1'b0;
        cfg_write_en = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        cmd_ch.valid = 1'b0;
        cmd_ch.opcode = '0;
        cmd_ch.temperature = '0;
        cmd_ch.tenth_tick = 1'b0;
        disp_ch.ready = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // display off straight out of reset
        queue_cmd(OP_SET, 16'd123, 1'b0);
        queue_cmd(OP_REFRESH, 16'hffff, 1'b1);
        queue_cmd(OP_SPARE, 16'h8000, 1'b1);
        queue_cmd(OP_REFRESH, 16'h7fff, 1'b0);
        settle();

        write_reg(REG_DISPLAY_MODE, 16'(MODE_ON));
        queue_cmd(OP_REFRESH, 16'h0000, 1'b1);
        settle();

        write_reg(REG_DISPLAY_MODE, 16'(MODE_NORMAL));
        queue_cmd(OP_SET, 16'd0, 1'b1);
        queue_cmd(OP_REFRESH, 16'h5555, 1'b0);
        queue_cmd(OP_SET, 16'd7, 1'b0);
        queue_cmd(OP_REFRESH, 16'haaaa, 1'b1);
        queue_cmd(OP_SET, 16'd1000, 1'b0);
        queue_cmd(OP_REFRESH, 16'h0000, 1'b0);
        queue_cmd(OP_SET, 16'd1001, 1'b0);
        queue_cmd(OP_REFRESH, 16'h0000, 1'b0);
        queue_cmd(OP_SET, 16'd1002, 1'b0);
        queue_cmd(OP_REFRESH, 16'h0000, 1'b0);
        queue_cmd(OP_SET, 16'h8000, 1'b0);
        queue_cmd(OP_REFRESH, 16'h0000, 1'b0);
        queue_cmd(OP_SET, -16'sd580, 1'b0);
        queue_cmd(OP_REFRESH, 16'h0000, 1'b0);
        queue_cmd(OP_SET, 16'd246, 1'b0);
        queue_cmd(OP_REFRESH, 16'h0000, 1'b0);
        queue_cmd(OP_SET, 16'd31, 1'b0);
        queue_cmd(OP_REFRESH, 16'h0000, 1'b0);
        settle();

        // blank wins over Lo and Hi, and Lo over Hi, when the codes collide
        write_reg(REG_DISPLAY_MODE, 16'(MODE_SPARE));
        write_reg(REG_BLANK_CODE, 16'h7fff);
        write_reg(REG_LOW_CODE, 16'h7fff);
        write_reg(REG_HIGH_CODE, 16'h7fff);
        queue_cmd(OP_SET, 16'h7fff, 1'b0);
        queue_cmd(OP_REFRESH, 16'h0000, 1'b0);
        settle();
        write_reg(REG_BLANK_CODE, 16'h0000);
        write_reg(REG_LOW_CODE, 16'h8000);
        write_reg(REG_HIGH_CODE, 16'h8000);
        queue_cmd(OP_SET, 16'h8000, 1'b0);
        queue_cmd(OP_REFRESH, 16'h0000, 1'b0);
        settle();

        for (int p = 0; p < 7; p++)
        begin
            case (p)
                2:       mode_pick = MODE_OFF;
                4:       mode_pick = MODE_SPARE;
                5:       mode_pick = MODE_ON;
                default: mode_pick = MODE_NORMAL;
            endcase
            write_reg(REG_DISPLAY_MODE, 16'(mode_pick));
            write_reg(REG_BLANK_CODE, pick_code());
            write_reg(REG_LOW_CODE, pick_code());
            write_reg(REG_HIGH_CODE, pick_code());
            steady = (p == 1 || p == 6);
            start = queued;
            while (queued - start < PHASE_ITEMS)
                queue_episode();
            settle();
        end

        if (errors == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end
endmodule
